@@ design/rrm_pkg.sv @@
// shared types, constants and table function for the range rule membership block
package rrm_pkg;

  localparam int FracBitsDef = 16;
  localparam int OutFracBits = 16;
  localparam int MembW       = OutFracBits + 1;
  localparam int QBits       = 24;
  localparam int PBits       = 30;
  localparam int QuotW       = 27;
  localparam int QueueDepth  = 4;
  localparam int QueuePtrW   = $clog2(QueueDepth);
  localparam int CfgIdxW     = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOW_CROSS  = 3'd0,
    REG_LOW_UNITY  = 3'd1,
    REG_HIGH_CROSS = 3'd2,
    REG_HIGH_UNITY = 3'd3,
    REG_LOW_ABSENT = 3'd4,
    REG_HIGH_ABSENT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] env_value;
    logic               no_data;
  } in_item_t;

  typedef struct packed {
    logic [MembW-1:0] membership;
    logic             width_error;
  } out_item_t;

  typedef struct packed {
    logic               one;
    logic [31:0]        span;
    logic signed [32:0] width;
  } cls_t;

  // entry k of the chain e[0] = 2^29, e[k] = isqrt(e[k-1] * 2^30)
  function automatic logic [63:0] exp_entry(input int k);
    logic [63:0] e;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    e = 64'd1 << (PBits - 1);
    for (int i = 1; i <= k; i++) begin
      v   = e << PBits;
      res = '0;
      b   = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      e = res;
    end
    return e;
  endfunction

endpackage

@@ design/rrm_front.sv @@
// configuration registers and item classification stage
module rrm_front import rrm_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_i,
  input  logic               q_full_i,
  output logic               push_o,
  output cls_t               cls_o
);

  localparam longint BigRaw = 64'sd1000 <<< FRAC_BITS;
  localparam longint Big    = (BigRaw > 64'sd2147483647) ? 64'sd2147483647 : BigRaw;
  localparam logic signed [31:0] HiCrossRst = 32'(Big);
  localparam logic signed [31:0] LoCrossRst = 32'(-Big);

  logic signed [31:0] lo_cross_q, lo_unity_q, hi_cross_q, hi_unity_q;
  logic               lo_absent_q, hi_absent_q;
  logic               fr_valid_q;
  cls_t               cls_q, cls_d;
  logic               fr_en;

  logic signed [32:0] x, lu, hu, lc, hc, lo_d, hi_d, lo_w, hi_w;
  logic               use_hi;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_cross_q  <= LoCrossRst;
      lo_unity_q  <= '0;
      hi_cross_q  <= HiCrossRst;
      hi_unity_q  <= '0;
      lo_absent_q <= 1'b0;
      hi_absent_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LOW_CROSS:   lo_cross_q  <= cfg_data_i;
        REG_LOW_UNITY:   lo_unity_q  <= cfg_data_i;
        REG_HIGH_CROSS:  hi_cross_q  <= cfg_data_i;
        REG_HIGH_UNITY:  hi_unity_q  <= cfg_data_i;
        REG_LOW_ABSENT:  lo_absent_q <= cfg_data_i[0];
        REG_HIGH_ABSENT: hi_absent_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    x    = {in_i.env_value[31], in_i.env_value};
    lu   = {lo_unity_q[31], lo_unity_q};
    hu   = {hi_unity_q[31], hi_unity_q};
    lc   = {lo_cross_q[31], lo_cross_q};
    hc   = {hi_cross_q[31], hi_cross_q};
    lo_d = lu - x;
    hi_d = x - hu;
    lo_w = lu - lc;
    hi_w = hc - hu;
    cls_d.one = 1'b0;
    use_hi    = 1'b0;
    if (in_i.no_data) begin
      cls_d.one = 1'b1;
    end else if (lo_absent_q) begin
      cls_d.one = x < hu;
      use_hi    = 1'b1;
    end else if (hi_absent_q) begin
      cls_d.one = x > lu;
    end else begin
      cls_d.one = (x < hu) && (x > lu);
      use_hi    = x > lu;
    end
    cls_d.span  = use_hi ? hi_d[31:0] : lo_d[31:0];
    cls_d.width = use_hi ? hi_w : lo_w;
  end

  assign fr_en      = !fr_valid_q || !q_full_i;
  assign in_stall_o = !fr_en;
  assign push_o     = fr_valid_q && !q_full_i;
  assign cls_o      = cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else if (fr_en) begin
      fr_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fr_en && in_valid_i) begin
      cls_q <= cls_d;
    end
  end

endmodule

@@ design/rrm_queue.sv @@
// small fifo between classification and evaluation
module rrm_queue import rrm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cls_t data_i,
  input  logic pop_i,
  output cls_t data_o,
  output logic full_o,
  output logic empty_o
);

  cls_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;

  assign full_o  = cnt_q == (QueuePtrW+1)'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(push_i) - (QueuePtrW+1)'(pop_i);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QueuePtrW+1)'(QueueDepth)) else $error("queue count out of range");
`endif

endmodule

@@ design/rrm_back.sv @@
// evaluation pipeline: ratio divider, square, exp2 product chain, output register
module rrm_back import rrm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cls_t      head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  localparam int DivStg = QuotW;
  localparam int SqStg  = DivStg + 1;
  localparam int ExpEnd = SqStg + QBits;
  localparam int NStg   = ExpEnd + 2;

  typedef struct packed {
    logic        one;
    logic        err;
    logic        zero;
    logic [31:0] w;
    logic [31:0] rem;
    logic [QuotW-1:0] q;
    logic [2:0]  dlo;
  } div_t;

  typedef struct packed {
    logic          one;
    logic          err;
    logic          zero;
    logic [4:0]    n;
    logic [QBits-1:0] f;
    logic [PBits:0]   p;
  } exp_t;

  logic      vld_q [NStg];
  div_t      div_q [DivStg+1];
  exp_t      exp_q [QBits+1];
  out_item_t out_q;
  logic      en;

  assign en          = !vld_q[NStg-1] || !out_stall_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = vld_q[NStg-1];
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NStg; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= !empty_i;
      for (int i = 1; i < NStg; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // width check and range cut
  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0].one  <= head_i.one;
      div_q[0].err  <= head_i.width[32] || (head_i.width == '0);
      div_q[0].zero <= {3'b000, head_i.span} >
                       ({1'b0, head_i.width[31:0], 2'b00} + {3'b000, head_i.width[31:0]});
      div_q[0].w    <= head_i.width[31:0];
      div_q[0].rem  <= {3'b000, head_i.span[31:3]};
      div_q[0].q    <= '0;
      div_q[0].dlo  <= head_i.span[2:0];
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DivStg; j++) begin : g_div
    localparam int Bi = QuotW - 1 - j;
    logic        nb;
    logic [32:0] trial;
    logic        ge;
    div_t        div_d;
    assign nb    = (Bi >= QBits) ? div_q[j].dlo[(Bi >= QBits) ? (Bi - QBits) : 0] : 1'b0;
    assign trial = {div_q[j].rem, nb};
    assign ge    = trial >= {1'b0, div_q[j].w};
    always_comb begin
      div_d       = div_q[j];
      div_d.rem   = ge ? 32'(trial - {1'b0, div_q[j].w}) : trial[31:0];
      div_d.q[Bi] = ge;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[j+1] <= div_d;
      end
    end
  end

  // squared ratio
  logic [2*QuotW-1:0] sq;
  assign sq = div_q[DivStg].q * div_q[DivStg].q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      exp_q[0].one  <= div_q[DivStg].one;
      exp_q[0].err  <= div_q[DivStg].err;
      exp_q[0].zero <= div_q[DivStg].zero;
      exp_q[0].n    <= sq[2*QBits +: 5];
      exp_q[0].f    <= sq[QBits +: QBits];
      exp_q[0].p    <= (PBits+1)'(1) << PBits;
    end
  end

  // exp2 of the negated fraction, one table factor per stage
  for (genvar k = 1; k <= QBits; k++) begin : g_exp
    localparam logic [63:0] ETab = exp_entry(k);
    logic [2*PBits:0] prod;
    exp_t             exp_d;
    assign prod = exp_q[k-1].p * ETab[PBits-1:0];
    always_comb begin
      exp_d = exp_q[k-1];
      if (exp_q[k-1].f[QBits-k]) begin
        exp_d.p = prod[PBits +: PBits+1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        exp_q[k] <= exp_d;
      end
    end
  end

  // integer part as a right shift, then result select
  exp_t        ef;
  logic [6:0]  sh;
  logic [PBits:0] psh;
  out_item_t   res;

  always_comb begin
    ef  = exp_q[QBits];
    sh  = 7'(PBits - OutFracBits) + 7'(ef.n);
    psh = ef.p >> sh;
    res.width_error = 1'b0;
    if (ef.one) begin
      res.membership = MembW'(1) << OutFracBits;
    end else if (ef.err) begin
      res.membership  = '0;
      res.width_error = 1'b1;
    end else if (ef.zero) begin
      res.membership = '0;
    end else begin
      res.membership = psh[MembW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.width_error |-> out_o.membership == '0)
    else $error("width error with nonzero grade");
  a_grade_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.membership <= (MembW'(1) << OutFracBits))
    else $error("grade above one");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result lost");
`endif

endmodule

@@ design/range_rule_membership.sv @@
// result path: front register, queue write, 54 back stages
// throughput: one item per cycle while the output is not stalled, as the divider and exp2 chain are fully pipelined
// a stalled valid output holds the back pipeline; the 4-entry queue lets the front keep taking items until it fills
// reset: asynchronous, active low; clears valids and queue, loads default curve registers
module range_rule_membership import rrm_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_o
);

  logic q_full, q_empty, push, pop;
  cls_t cls, head;

  rrm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_i,
    .q_full_i(q_full), .push_o(push), .cls_o(cls)
  );

  rrm_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(cls), .pop_i(pop),
    .data_o(head), .full_o(q_full), .empty_o(q_empty)
  );

  rrm_back u_back (
    .clk_i, .rst_ni, .head_i(head), .empty_i(q_empty), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_o
  );

endmodule

@@ tb/range_rule_membership_tb.sv @@
// testbench for range_rule_membership: random and directed cells checked against a local curve model
module range_rule_membership_tb import rrm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] RegSpare = 3'd6;
  localparam logic [CfgIdxW-1:0] RegLast  = 3'd7;
  localparam longint CycleLimit = 2000000;
  localparam int     HoldCycles = 400;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_item_t           in_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_o;

  range_rule_membership u_top (.*);

  // curve registers as seen by the predictor
  longint lo_cross, lo_unity, hi_cross, hi_unity;
  bit     lo_absent, hi_absent;
  logic [63:0] exp2_frac [QBits+1];

  in_item_t  cells_pending[$];
  out_item_t grades_due[$];
  int        mismatches = 0;
  longint    cycle_cnt = 0;

  initial forever #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] side_grade(longint d, longint w, ref bit err);
    logic [63:0] ud, uw, q, t, f, p;
    int n;
    if (w <= 0) begin
      err = 1'b1;
      return 0;
    end
    ud = d;
    uw = w;
    if (ud > 5 * uw) return 0;
    q = ((ud / uw) << QBits) | (((ud % uw) << QBits) / uw);
    t = (q * q) >> QBits;
    n = int'(t >> QBits);
    f = t & ((64'd1 << QBits) - 1);
    p = 64'd1 << PBits;
    for (int k = 1; k <= QBits; k++)
      if (f[QBits-k]) p = (p * exp2_frac[k]) >> PBits;
    return p >> (PBits + n - OutFracBits);
  endfunction

  function automatic out_item_t membership_of(in_item_t c);
    longint x;
    logic [63:0] g;
    bit err;
    out_item_t r;
    logic [63:0] one;
    one = 64'd1 << OutFracBits;
    err = 1'b0;
    x = longint'(c.env_value);
    if (c.no_data) g = one;
    else if (lo_absent) begin
      if (x < hi_unity) g = one;
      else g = side_grade(x - hi_unity, hi_cross - hi_unity, err);
    end else if (hi_absent) begin
      if (x > lo_unity) g = one;
      else g = side_grade(lo_unity - x, lo_unity - lo_cross, err);
    end else begin
      if (x < hi_unity && x > lo_unity) g = one;
      else if (x <= lo_unity) g = side_grade(lo_unity - x, lo_unity - lo_cross, err);
      else g = side_grade(x - hi_unity, hi_cross - hi_unity, err);
    end
    r.membership  = g[MembW-1:0];
    r.width_error = err;
    return r;
  endfunction

  // sender: bursts with random gaps, valid held while stalled
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        grades_due.push_back(membership_of(in_i));
        void'(cells_pending.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (cells_pending.size() > 0) begin
          in_valid_i <= 1'b1;
          in_i <= cells_pending[0];
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall pattern from three modes, plus one long hold-off
  int stall_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int grades_seen = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        grades_seen++;
        if (grades_due.size() == 0) begin
          $error("unexpected transfer: membership %0d width_error %0d",
                 out_o.membership, out_o.width_error);
          mismatches++;
        end else begin
          out_item_t e;
          e = grades_due.pop_front();
          if (out_o.membership !== e.membership) begin
            $error("membership: expected %0d actual %0d", e.membership, out_o.membership);
            mismatches++;
          end
          if (out_o.width_error !== e.width_error) begin
            $error("width_error: expected %0d actual %0d", e.width_error, out_o.width_error);
            mismatches++;
          end
        end
      end
      if (cycle_cnt % 64 == 0) stall_mode = $urandom_range(0, 2);
      if (!hold_done && grades_seen >= 20) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 9) < 3);
          default: out_stall_i <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_LOW_CROSS:   lo_cross  = longint'($signed(data));
      REG_LOW_UNITY:   lo_unity  = longint'($signed(data));
      REG_HIGH_CROSS:  hi_cross  = longint'($signed(data));
      REG_HIGH_UNITY:  hi_unity  = longint'($signed(data));
      REG_LOW_ABSENT:  lo_absent = data[0];
      REG_HIGH_ABSENT: hi_absent = data[0];
      default: ;
    endcase
  endtask

  task automatic set_curve(int lc, int lu, int hc, int hu, bit la, bit ha);
    write_reg(REG_LOW_CROSS, lc);
    write_reg(REG_LOW_UNITY, lu);
    write_reg(REG_HIGH_CROSS, hc);
    write_reg(REG_HIGH_UNITY, hu);
    write_reg(REG_LOW_ABSENT, {$urandom_range(0, 1) ? 31'h7fffffff : 31'h0, la});
    write_reg(REG_HIGH_ABSENT, {31'h0, ha});
  endtask

  task automatic wait_drained();
    wait (cells_pending.size() == 0 && grades_due.size() == 0);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic int near_point();
    longint pts[4];
    longint w;
    pts = '{lo_cross, lo_unity, hi_cross, hi_unity};
    w = hi_cross - hi_unity;
    if (w < 0) w = -w;
    if (w == 0 || w > 64'h7fffffff) w = 65536;
    case ($urandom_range(0, 3))
      0: return int'(pts[$urandom_range(0, 3)]) + $urandom_range(0, 6) - 3;
      1: return int'(pts[$urandom_range(0, 3)] + longint'($urandom_range(0, 2 * w)) - w);
      2: return int'(pts[$urandom_range(0, 3)] + longint'($urandom_range(0, 12 * w)) - 6 * w);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_cell(int v, bit nd);
    in_item_t c;
    c.env_value = v;
    c.no_data = nd;
    cells_pending.push_back(c);
  endtask

  task automatic random_cells(int cnt);
    for (int i = 0; i < cnt; i++)
      push_cell(near_point(), $urandom_range(0, 15) == 0);
  endtask

  int rc, ru, rw;
  initial begin
    lo_cross = -(64'sd1000 << 16);
    lo_unity = 0;
    hi_cross = 64'sd1000 << 16;
    hi_unity = 0;
    lo_absent = 1'b0;
    hi_absent = 1'b0;
    exp2_frac[0] = 64'd1 << (PBits - 1);
    for (int k = 1; k <= QBits; k++) exp2_frac[k] = int_sqrt(exp2_frac[k-1] << PBits);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed cells under the reset curve
    push_cell(32'h80000000, 1'b0);
    push_cell(32'h7fffffff, 1'b0);
    push_cell(32'h80000000, 1'b1);
    push_cell(32'h7fffffff, 1'b1);
    push_cell(0, 1'b0);
    push_cell(0, 1'b1);
    push_cell(1000 << 16, 1'b0);
    push_cell(-(1000 << 16), 1'b0);
    push_cell(5000 << 16, 1'b0);
    push_cell((5000 << 16) + 1, 1'b0);
    push_cell(-(5000 << 16), 1'b0);
    push_cell(1, 1'b0);
    push_cell(-1, 1'b0);
    push_cell(32'h55555555, 1'b0);
    push_cell(32'haaaaaaaa, 1'b0);
    random_cells(150);
    wait_drained();

    // extreme registers, unity band in the middle
    set_curve(32'h80000000, -(1 << 16), 32'h7fffffff, 1 << 16, 1'b0, 1'b0);
    random_cells(150);
    wait_drained();
    // z shape, then both flags set
    set_curve(-(10 << 16), -(5 << 16), 7 << 16, 2 << 16, 1'b1, 1'b0);
    random_cells(150);
    wait_drained();
    write_reg(REG_HIGH_ABSENT, 32'h1);
    write_reg(RegSpare, 32'h12345678);
    write_reg(RegLast, 32'hffffffff);
    random_cells(120);
    wait_drained();
    // s shape
    set_curve(-(3 << 16), 100, 9 << 16, 0, 1'b0, 1'b1);
    random_cells(150);
    wait_drained();
    // nonpositive widths on both sides
    set_curve(5 << 16, 5 << 16, -(4 << 16), 2 << 16, 1'b0, 1'b0);
    random_cells(150);
    wait_drained();
    set_curve(32'h7fffffff, 0, 32'h80000000, 0, 1'b0, 1'b0);
    random_cells(100);
    wait_drained();
    // empty band
    set_curve(-(20 << 16), 8 << 16, 30 << 16, -(3 << 16), 1'b0, 1'b0);
    random_cells(150);
    wait_drained();
    // tiny widths
    set_curve(-1, 0, 3, 2, 1'b0, 1'b0);
    random_cells(120);
    wait_drained();
    repeat (5) begin
      ru = $urandom;
      rw = $urandom_range(1, 1 << $urandom_range(0, 30));
      rc = $urandom;
      set_curve(ru - rw, ru, rc, rc - $urandom_range(0, 1 << $urandom_range(0, 30)),
                $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      random_cells(120);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
